>>> rtl/core/psia_pkg.sv
`timescale 1ns / 1ps
package psia_pkg;

    localparam int REQ_W         = 2;
    localparam int SLOT_W        = 6;
    localparam int ID_W          = 31;
    localparam int DEF_NUM_SLOTS = 64;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_COMMIT  = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_NOP     = 2'd3
    } t_req;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic run;
        logic push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic req_alloc;
        logic alloc_done;
        logic out_free;
    } t_stat;

    // counter advance, wraps past the positive maximum to 1, and 0 goes to 1
    function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] v);
        logic [ID_W-1:0] r;
        if (v == ID_MAX) begin
            r = {{(ID_W-1){1'b0}}, 1'b1};
        end else begin
            r = v + {{(ID_W-1){1'b0}}, 1'b1};
        end
        return r;
    endfunction

endpackage

>>> rtl/core/psia_ctrl.sv
`timescale 1ns / 1ps
module psia_ctrl import psia_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_in_stall;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:   o_cmd.start = i_in_valid;
            S_SCAN:   o_cmd.run   = 1'b1;
            S_FINISH: o_cmd.push  = i_stat.out_free;
            default:  o_cmd       = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in_stall <= 1'b1;
                        r_state    <= i_stat.req_alloc ? S_SCAN : S_FINISH;
                    end
                end
                S_SCAN: begin
                    if (i_stat.alloc_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_stat.out_free) begin
                        r_in_stall <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_stall <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

>>> rtl/core/psia_dp.sv
`timescale 1ns / 1ps
module psia_dp import psia_pkg::*; #(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [SLOT_W-1:0] i_slot_index,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_status,
    output logic [SLOT_W-1:0] o_granted_slot,
    output logic [ID_W-1:0]   o_granted_id
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int KW = $clog2(NUM_SLOTS + 1);
    localparam int TW = $clog2(NUM_SLOTS + 2);
    localparam int IW = (AW > SLOT_W) ? AW : SLOT_W;

    logic [ID_W-1:0]      r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;
    logic [ID_W-1:0]      r_last_id;
    t_req                 r_req;
    logic [SLOT_W-1:0]    r_idx;

    // identifier clash scan
    logic [KW-1:0]        r_k;
    logic                 r_rd_vld;
    logic [ID_W-1:0]      r_rd_data;
    logic                 r_rd_hit;
    logic [TW-1:0]        r_tries;
    logic                 r_clash_done;

    // free slot search
    logic [KW-1:0]        r_f;
    logic                 r_free_found;
    logic [AW-1:0]        r_free_slot;

    logic                 r_out_valid;
    logic                 r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [ID_W-1:0]      r_out_id;

    t_req                 in_req;
    logic [IW-1:0]        idx_w;
    logic                 in_range;
    logic [AW-1:0]        wr_addr;
    logic                 issue;
    logic                 clash;
    logic                 free_run;
    logic                 free_done;
    logic                 out_free;

    assign in_req   = t_req'(i_req_type);
    assign idx_w    = IW'(i_slot_index);
    assign in_range = {1'b0, idx_w} < (IW + 1)'(NUM_SLOTS);
    assign wr_addr  = idx_w[AW-1:0];

    assign issue     = r_k < KW'(NUM_SLOTS);
    assign clash     = r_rd_vld && r_rd_hit && (r_rd_data == r_last_id);
    assign free_run  = i_cmd.run && !r_free_found && (r_f < KW'(NUM_SLOTS));
    assign free_done = r_free_found || (r_f == KW'(NUM_SLOTS));
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.req_alloc  = (in_req == REQ_ALLOC);
        o_stat.alloc_done = r_clash_done && free_done;
        o_stat.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_id    <= '0;
            r_valid      <= '0;
            r_k          <= '0;
            r_rd_vld     <= 1'b0;
            r_tries      <= '0;
            r_clash_done <= 1'b0;
            r_f          <= '0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                case (in_req)
                    REQ_ALLOC: begin
                        r_last_id    <= next_id(r_last_id);
                        r_k          <= '0;
                        r_rd_vld     <= 1'b0;
                        r_tries      <= '0;
                        r_clash_done <= 1'b0;
                        r_f          <= KW'(1);
                        r_free_found <= 1'b0;
                    end
                    REQ_COMMIT: begin
                        if (in_range) begin
                            r_valid[wr_addr] <= 1'b1;
                        end
                    end
                    REQ_RELEASE: begin
                        if (in_range) begin
                            r_valid[wr_addr] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            if (i_cmd.run && !r_clash_done) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_k <= r_k + KW'(1);
                end
                if (clash) begin
                    r_last_id <= next_id(r_last_id);
                    r_tries   <= r_tries + TW'(1);
                    if (r_tries == TW'(NUM_SLOTS)) begin
                        r_clash_done <= 1'b1;
                    end else begin
                        // restart the pass with the new candidate
                        r_k      <= '0;
                        r_rd_vld <= 1'b0;
                    end
                end else if (!issue && !r_rd_vld) begin
                    r_clash_done <= 1'b1;
                end
            end

            if (free_run) begin
                if (!r_valid[r_f[AW-1:0]]) begin
                    r_free_found <= 1'b1;
                end else begin
                    r_f <= r_f + KW'(1);
                end
            end

            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= in_req;
            r_idx <= i_slot_index;
            if (in_req == REQ_COMMIT && in_range) begin
                r_mem[wr_addr] <= r_last_id;
            end
        end
        if (i_cmd.run && issue) begin
            r_rd_data <= r_mem[r_k[AW-1:0]];
            r_rd_hit  <= r_valid[r_k[AW-1:0]];
        end
        if (free_run) begin
            r_free_slot <= r_f[AW-1:0];
        end
        if (i_cmd.push) begin
            r_out_id <= r_last_id;
            if (r_req == REQ_ALLOC) begin
                r_out_status <= !r_free_found;
                r_out_slot   <= r_free_found ? SLOT_W'(r_free_slot) : '0;
            end else begin
                r_out_status <= 1'b0;
                r_out_slot   <= r_idx;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_granted_slot = r_out_slot;
    assign o_granted_id   = r_out_id;

endmodule

>>> rtl/core/process_slot_and_id_allocator.sv
// commit, release and no-op: S_FINISH registers the result once the output is free
// allocate: each identifier clash met restarts the scan of the identifier memory;
//   the scan reads one entry per cycle, alongside the free slot search
// one request in flight; the next is taken once the result sits in the output register
// reset (sync, active low) clears the counter and all slot valid marks at once;
//   slot identifiers are undefined until committed and need no clearing pass
`timescale 1ns / 1ps
module process_slot_and_id_allocator import psia_pkg::*; #(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [SLOT_W-1:0] i_slot_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_status,
    output logic [SLOT_W-1:0] o_granted_slot,
    output logic [ID_W-1:0]   o_granted_id
);

    t_cmd  w_cmd;
    t_stat w_stat;

    psia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    psia_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_req_type     (i_req_type),
        .i_slot_index   (i_slot_index),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_granted_id   (o_granted_id)
    );

`ifndef SYNTHESIS
    // block is busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepted transaction");

    // result only loaded when the output register can take it
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> w_stat.out_free)
        else $error("result pushed over a waiting result");

    // failed allocate reports slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_granted_slot == '0)
        else $error("no-free-slot status with nonzero slot");
`endif

endmodule
